### rtl/core/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

    localparam int CFG_W          = 10;
    localparam int CFG_IDX_W      = 1;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 3;
    localparam int SUM_W          = 12;
    localparam int RECIP_W        = 13;
    localparam int PROD_W         = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT    = 16;
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0]   CFG_SIZE_RESET = 10'd512;
    localparam logic [RECIP_W-1:0] RECIP_NINE     = 13'd7282;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [NUM_CHAN-1:0] pix_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef sum_t [NUM_CHAN-1:0] sums_t;

    typedef struct packed {
        logic in_image;
        logic emit;
        logic last;
    } pos_t;

    // floor(sum / 9) by reciprocal multiply, exact for sums of nine 8-bit values
    function automatic chan_t mean9(input sum_t sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(RECIP_NINE);
        return prod[RECIP_SHIFT +: CHAN_W];
    endfunction

endpackage

`default_nettype wire

### rtl/core/rgb_box_blur_3x3.sv
// 3x3 box blur over a pixel stream in raster order.
// input channel: in_valid/in_ready with red_in, green_in, blue_in. the frame is
// sent as (image_width + 2) columns by (image_height + 2) rows: two padding
// columns close every row and two padding rows close the frame; padding values
// are ignored and count as zero, as do pixels beyond the image edge.
// output channel: out_valid/out_ready with red_out, green_out, blue_out and
// frame_last. each output is the truncated mean of nine pixels, window at its
// top-left, one per image pixel; frame_last marks the final one.
// configuration: cfg_we, cfg_index (0 width, 1 height), cfg_data; write only
// while the block is idle.
// throughput: one item per cycle while the output does not stall. an item is
// registered in the line memory read, window, adder tree and output mean stages.
// the two previous rows sit in one line memory read and written back per column.
// reset clears the position counters, the window and the pipeline valid flags;
// width and height return to 512. while out_valid is high and out_ready low the
// whole pipeline holds and in_ready is low.
`default_nettype none

module rgb_box_blur_3x3 import bb3_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire logic [CHAN_W-1:0]    red_in,
    input  wire logic [CHAN_W-1:0]    green_in,
    input  wire logic [CHAN_W-1:0]    blue_in,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic [CHAN_W-1:0]    red_out,
    output      logic [CHAN_W-1:0]    green_out,
    output      logic [CHAN_W-1:0]    blue_out,
    output      logic                 frame_last
);

    localparam int LINE_DEPTH = MAX_WIDTH + 2;
    localparam int COL_W      = $clog2(LINE_DEPTH);
    localparam int PIX_W      = NUM_CHAN * CHAN_W;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic             en, accept;
    logic [COL_W-1:0] col;
    pos_t             pos;
    pix_t             pix_in;

    logic             s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [COL_W-1:0] s1_col_reg;
    pix_t             s1_pix_reg;
    logic             s2_emit_reg, s2_last_reg;
    logic             s3_emit_reg, s3_last_reg;
    logic             out_valid_reg;
    pix_t             out_pix_reg;
    logic             out_last_reg;

    logic [2*PIX_W-1:0] line_rdata, line_wdata;
    pix_t               top, mid;
    sums_t              sums;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_SIZE_RESET;
            height_reg <= CFG_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;

    bb3_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .image_width  (width_reg),
        .image_height (height_reg),
        .col          (col),
        .pos          (pos)
    );

    assign pix_in[0] = red_in;
    assign pix_in[1] = green_in;
    assign pix_in[2] = blue_in;

    // line memory entry: older row in the upper half, newer row in the lower
    assign top        = line_rdata[2*PIX_W-1:PIX_W];
    assign mid        = line_rdata[PIX_W-1:0];
    assign line_wdata = {mid, s1_pix_reg};

    bb3_ram #(
        .DATA_W (2 * PIX_W),
        .DEPTH  (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (en && s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (col),
        .rdata (line_rdata)
    );

    bb3_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (en && s1_valid_reg),
        .sum_en   (en),
        .top      (top),
        .mid      (mid),
        .bot      (s1_pix_reg),
        .sums     (sums)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_emit_reg   <= 1'b0;
            s2_emit_reg   <= 1'b0;
            s3_emit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= accept;
            s1_emit_reg   <= accept && pos.emit;
            s2_emit_reg   <= s1_valid_reg && s1_emit_reg;
            s3_emit_reg   <= s2_emit_reg;
            out_valid_reg <= s3_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_col_reg   <= col;
            s1_pix_reg   <= pos.in_image ? pix_in : '0;
            s1_last_reg  <= pos.last;
            s2_last_reg  <= s1_last_reg;
            s3_last_reg  <= s2_last_reg;
            out_last_reg <= s3_last_reg;
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                out_pix_reg[ch] <= mean9(sums[ch]);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = out_pix_reg[0];
    assign green_out  = out_pix_reg[1];
    assign blue_out   = out_pix_reg[2];
    assign frame_last = out_last_reg;

endmodule

`default_nettype wire

### rtl/core/bb3_ram.sv
`default_nettype none

module bb3_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 514
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/bb3_pos.sv
`default_nettype none

module bb3_pos import bb3_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire logic [CFG_W-1:0]                  image_width,
    input  wire logic [CFG_W-1:0]                  image_height,
    output      logic [$clog2(MAX_WIDTH + 2)-1:0]  col,
    output      pos_t                              pos
);

    localparam int COL_W = $clog2(MAX_WIDTH + 2);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    logic [COL_W-1:0] col_reg, col_next, w_eff, w_last;
    logic [ROW_W-1:0] row_reg, row_next, h_eff, h_last, row;
    logic             last_col, last_row;

    always_comb
    begin
        if (image_width == '0)
            w_eff = COL_W'(1);
        else if (32'(image_width) > MAX_WIDTH)
            w_eff = COL_W'(MAX_WIDTH);
        else
            w_eff = COL_W'(image_width);

        if (image_height == '0)
            h_eff = ROW_W'(1);
        else if (32'(image_height) > MAX_HEIGHT)
            h_eff = ROW_W'(MAX_HEIGHT);
        else
            h_eff = ROW_W'(image_height);
    end

    assign w_last = w_eff + COL_W'(1);
    assign h_last = h_eff + ROW_W'(1);

    // positions past the padded grid after a size change
    assign col = (col_reg > w_last) ? w_last : col_reg;
    assign row = (row_reg > h_last) ? h_last : row_reg;

    assign last_col = (col == w_last);
    assign last_row = (row == h_last);

    assign pos.in_image = (row < h_eff) && (col < w_eff);
    assign pos.emit     = (row >= ROW_W'(2)) && (col >= COL_W'(2));
    assign pos.last     = last_col && last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row + ROW_W'(1);
            end
            else
            begin
                col_next = col + COL_W'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bb3_window.sv
`default_nettype none

module bb3_window import bb3_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  shift_en,
    input  wire logic  sum_en,
    input  wire pix_t  top,
    input  wire pix_t  mid,
    input  wire pix_t  bot,
    output      sums_t sums
);

    pix_t  win_reg [3][3];
    pix_t  col_new [3];
    sums_t sums_reg, sums_next;

    assign col_new[0] = top;
    assign col_new[1] = mid;
    assign col_new[2] = bot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (shift_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
                win_reg[r][2] <= col_new[r];
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            sums_next[ch] = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sums_next[ch] = sums_next[ch] + SUM_W'(win_reg[r][c][ch]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_en)
        begin
            sums_reg <= sums_next;
        end
    end

    assign sums = sums_reg;

endmodule

`default_nettype wire
